@@ rtl/ttc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

  // Field widths
  localparam int unsigned TsW    = 32;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned WdayW  = 3;

  // Seconds left within one year fit in this many bits
  localparam int unsigned RemW = 25;
  // Divider quotient register (widest quotient is the minute)
  localparam int unsigned QuoW = 6;

  localparam logic [TsW:0]     SecsPerCommonYear = 33'd31536000;
  localparam logic [TsW:0]     SecsPerDay        = 33'd86400;
  localparam logic [RemW-1:0]  SecsPerHour       = 25'd3600;
  localparam logic [RemW-1:0]  SecsPerMinute     = 25'd60;
  localparam logic [YearW-1:0] EpochYear         = 12'd1970;
  // 1970-01-01 was a Thursday; weekdays count from Monday = 0 internally
  localparam logic [WdayW-1:0] EpochWeekday      = 3'd3;
  localparam logic [MonthW-1:0] LastMonthIdx     = 4'd11;

  // Reciprocals for x / (2^p * d) = ((x >> p) * m) >> s over the ranges in use
  localparam logic [15:0] DayRecip  = 16'd49711;  // 86400 = 2^7 * 675, s = 25
  localparam logic [15:0] HourRecip = 16'd9321;   // 3600 = 2^4 * 225, s = 21
  localparam logic [15:0] MinRecip  = 16'd1093;   // 60 = 2^2 * 15, s = 14

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     year_step;
    logic     month_step;
    logic     div_step;
    div_sel_e div_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic div_last;
  } status_t;

  // Leap-year rule; every year reachable from a 32-bit count lies in
  // 1970..2106, where 2000 is the only multiple of 400 and 2100 the only
  // other century year.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    return (y[1:0] == 2'd0) && (y != 12'd2100);
  endfunction

  // Month length in days, month index 0 is January
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] idx,
                                                 input logic leap);
    logic [DayW-1:0] d;
    case (idx)
      4'd1:                    d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  // Weekday (0..6) advanced by a small day count, modulo 7
  function automatic logic [WdayW-1:0] wday_add(input logic [WdayW-1:0] a,
                                                input logic [DayW-1:0] b);
    logic [DayW:0] s;
    s = {3'd0, a} + {1'b0, b};
    for (int i = 0; i < 5; i++) begin
      if (s >= 6'd7) begin
        s = s - 6'd7;
      end
    end
    return s[WdayW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/timestamp_to_calendar_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_ready_o  seconds_since_epoch_i[31:0]
// output    out        out_valid_o/out_ready_i year_o, month_o, day_of_month_o,
//                                             hour_o, minute_o, second_o, weekday_o
//
// An item passes through a load, the year loop in the datapath (one year per
// cycle), the month loop and the shared reciprocal divider (an estimate step and
// a subtract step each for day, hour, minute), then the output register load.
// Reset clears only the controller state and the output valid flag.
// A new item is taken while a result still waits; a finished conversion holds
// in the datapath until the output register is free.

module timestamp_to_calendar_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ttc_pkg::TsW-1:0]       seconds_since_epoch_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [ttc_pkg::YearW-1:0]     year_o,
  output logic      [ttc_pkg::MonthW-1:0]    month_o,
  output logic      [ttc_pkg::DayW-1:0]      day_of_month_o,
  output logic      [ttc_pkg::HourW-1:0]     hour_o,
  output logic      [ttc_pkg::MinW-1:0]      minute_o,
  output logic      [ttc_pkg::SecW-1:0]      second_o,
  output logic      [ttc_pkg::WdayW-1:0]     weekday_o
);

  ttc_pkg::cmd_t    cmd;
  ttc_pkg::status_t status;

  ttc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ttc_datapath u_datapath (
    .clk_i                 (clk_i),
    .cmd_i                 (cmd),
    .status_o              (status),
    .seconds_since_epoch_i (seconds_since_epoch_i),
    .year_o                (year_o),
    .month_o               (month_o),
    .day_of_month_o        (day_of_month_o),
    .hour_o                (hour_o),
    .minute_o              (minute_o),
    .second_o              (second_o),
    .weekday_o             (weekday_o)
  );

endmodule

`default_nettype wire

@@ rtl/ttc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ttc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire ttc_pkg::status_t status_i,
  output ttc_pkg::cmd_t         cmd_o
);

  ttc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // State and output flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.div_sel  = ttc_pkg::DIV_DAY;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ttc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ttc_pkg::ST_YEAR;
        end
      end
      ttc_pkg::ST_YEAR: begin
        cmd_o.year_step = 1'b1;
        if (status_i.year_done) begin
          state_d = ttc_pkg::ST_MONTH;
        end
      end
      ttc_pkg::ST_MONTH: begin
        cmd_o.month_step = 1'b1;
        if (status_i.month_done) begin
          state_d = ttc_pkg::ST_DIV_DAY;
        end
      end
      ttc_pkg::ST_DIV_DAY: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = ttc_pkg::DIV_DAY;
        if (status_i.div_last) begin
          state_d = ttc_pkg::ST_DIV_HOUR;
        end
      end
      ttc_pkg::ST_DIV_HOUR: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = ttc_pkg::DIV_HOUR;
        if (status_i.div_last) begin
          state_d = ttc_pkg::ST_DIV_MIN;
        end
      end
      ttc_pkg::ST_DIV_MIN: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = ttc_pkg::DIV_MIN;
        if (status_i.div_last) begin
          state_d = ttc_pkg::ST_DONE;
        end
      end
      ttc_pkg::ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ttc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ttc_pkg::ST_IDLE;
      end
    endcase
  end

  // Set on load, drop after the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/ttc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ttc_datapath (
  input  wire logic                          clk_i,
  input  wire ttc_pkg::cmd_t                 cmd_i,
  output ttc_pkg::status_t                   status_o,
  input  wire logic [ttc_pkg::TsW-1:0]       seconds_since_epoch_i,
  output logic      [ttc_pkg::YearW-1:0]     year_o,
  output logic      [ttc_pkg::MonthW-1:0]    month_o,
  output logic      [ttc_pkg::DayW-1:0]      day_of_month_o,
  output logic      [ttc_pkg::HourW-1:0]     hour_o,
  output logic      [ttc_pkg::MinW-1:0]      minute_o,
  output logic      [ttc_pkg::SecW-1:0]      second_o,
  output logic      [ttc_pkg::WdayW-1:0]     weekday_o
);

  logic [ttc_pkg::TsW-1:0]    ts_q;
  logic [ttc_pkg::TsW-1:0]    ystart_q;
  logic [ttc_pkg::YearW-1:0]  year_q;
  logic [ttc_pkg::WdayW-1:0]  wd_q;
  logic [ttc_pkg::RemW-1:0]   rem_q;
  logic [ttc_pkg::MonthW-1:0] mon_q;
  logic [ttc_pkg::QuoW-1:0]   quo_q;
  logic                       k_q;
  logic [ttc_pkg::DayW-1:0]   day_q;
  logic [ttc_pkg::HourW-1:0]  hour_q;

  logic                       leap;
  logic [ttc_pkg::TsW:0]      next_start;
  logic [ttc_pkg::DayW-1:0]   mdays;
  logic [ttc_pkg::RemW-1:0]   msecs;
  logic [ttc_pkg::RemW-1:0]   divisor;
  logic [14:0]                recip_x;
  logic [15:0]                recip_m;
  logic [30:0]                recip_p;
  logic [ttc_pkg::QuoW-1:0]   quo_est;
  logic [ttc_pkg::RemW-1:0]   quo_secs;

  assign leap = ttc_pkg::is_leap(year_q);

  // Start of the following year
  assign next_start = {1'b0, ystart_q} + ttc_pkg::SecsPerCommonYear
                    + (leap ? ttc_pkg::SecsPerDay : '0);

  // Length of the current month in seconds
  assign mdays = ttc_pkg::month_days(mon_q, leap);
  assign msecs = ttc_pkg::RemW'(mdays) * ttc_pkg::SecsPerDay[ttc_pkg::RemW-1:0];

  // Divisor of the current phase, with the remainder pre-shifted by its power-of-two factor;
  // the remainder is below 31 days, one day or one hour in the three phases
  always_comb begin
    case (cmd_i.div_sel)
      ttc_pkg::DIV_DAY: begin
        divisor = ttc_pkg::SecsPerDay[ttc_pkg::RemW-1:0];
        recip_x = rem_q[21:7];
        recip_m = ttc_pkg::DayRecip;
      end
      ttc_pkg::DIV_HOUR: begin
        divisor = ttc_pkg::SecsPerHour;
        recip_x = {2'd0, rem_q[16:4]};
        recip_m = ttc_pkg::HourRecip;
      end
      default: begin
        divisor = ttc_pkg::SecsPerMinute;
        recip_x = {5'd0, rem_q[11:2]};
        recip_m = ttc_pkg::MinRecip;
      end
    endcase
  end

  assign recip_p = 31'(recip_x) * 31'(recip_m);

  // Quotient is the product shifted down by the phase's reciprocal scale
  always_comb begin
    case (cmd_i.div_sel)
      ttc_pkg::DIV_DAY:  quo_est = recip_p[30:25];
      ttc_pkg::DIV_HOUR: quo_est = recip_p[26:21];
      default:           quo_est = recip_p[19:14];
    endcase
  end

  assign quo_secs = ttc_pkg::RemW'(quo_q) * divisor;

  assign status_o.year_done  = next_start > {1'b0, ts_q};
  assign status_o.month_done = (rem_q < msecs) || (mon_q == ttc_pkg::LastMonthIdx);
  assign status_o.div_last   = (k_q == 1'b0);

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ts_q     <= seconds_since_epoch_i;
      ystart_q <= '0;
      year_q   <= ttc_pkg::EpochYear;
      wd_q     <= ttc_pkg::EpochWeekday;
    end

    // Step off whole years; on the last step keep the seconds into the year
    if (cmd_i.year_step) begin
      if (status_o.year_done) begin
        rem_q <= ttc_pkg::RemW'(ts_q - ystart_q);
        mon_q <= '0;
      end else begin
        ystart_q <= next_start[ttc_pkg::TsW-1:0];
        year_q   <= year_q + 12'd1;
        wd_q     <= ttc_pkg::wday_add(wd_q, leap ? 5'd2 : 5'd1);
      end
    end

    // Step off whole months; then arm the divider for the day
    if (cmd_i.month_step) begin
      if (status_o.month_done) begin
        k_q   <= 1'b1;
        quo_q <= '0;
      end else begin
        rem_q <= rem_q - msecs;
        mon_q <= mon_q + 4'd1;
        wd_q  <= ttc_pkg::wday_add(wd_q, mdays - 5'd28);
      end
    end

    // Reciprocal division: estimate the quotient, then take off its seconds
    if (cmd_i.div_step) begin
      if (status_o.div_last) begin
        rem_q <= rem_q - quo_secs;
        k_q   <= 1'b1;
        case (cmd_i.div_sel)
          ttc_pkg::DIV_DAY: begin
            day_q <= quo_q[ttc_pkg::DayW-1:0];
            wd_q  <= ttc_pkg::wday_add(wd_q, quo_q[ttc_pkg::DayW-1:0]);
          end
          ttc_pkg::DIV_HOUR: begin
            hour_q <= quo_q[ttc_pkg::HourW-1:0];
          end
          default: begin
          end
        endcase
      end else begin
        quo_q <= quo_est;
        k_q   <= 1'b0;
      end
    end
  end

  // Output register; the minute is the last quotient, the second what is left
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      year_o         <= year_q;
      month_o        <= mon_q + 4'd1;
      day_of_month_o <= day_q + 5'd1;
      hour_o         <= hour_q;
      minute_o       <= quo_q;
      second_o       <= rem_q[ttc_pkg::SecW-1:0];
      weekday_o      <= wd_q + 3'd1;
    end
  end

endmodule

`default_nettype wire
